// ===== hw/rtl/rpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pkg: shared types and constants of the rotary pulse dial decoder
// Holds the register map, reset values and the word types passed between
// the top level and the decoder core.
// ----------------------------------------------------------------------------
package rpd_pkg;

	// Timer width default and configuration port geometry.
	localparam int TIMER_BITS_DEFAULT = 16;
	localparam int CFG_IDX_BITS       = 3;
	localparam int CFG_DATA_BITS      = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BREAK_MIN     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BREAK_MAX     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAKE_MIN      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAP           = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_LIMIT   = 3'd5;

	// Register reset values.
	localparam logic [9:0]  RST_EDGE_DEBOUNCE = 10'd22;
	localparam logic [9:0]  RST_BREAK_MIN     = 10'd28;
	localparam logic [9:0]  RST_BREAK_MAX     = 10'd220;
	localparam logic [9:0]  RST_MAKE_MIN      = 10'd28;
	localparam logic [15:0] RST_GAP           = 16'd700;
	localparam logic [4:0]  RST_PULSE_LIMIT   = 5'd20;

	// Ten pulses dial the digit zero.
	localparam logic [4:0]  TEN_PULSES = 5'd10;

	// Configuration registers as seen by the core.
	typedef struct packed {
		logic [9:0]  edge_debounce_ms;
		logic [9:0]  break_min_ms;
		logic [9:0]  break_max_ms;
		logic [9:0]  make_min_ms;
		logic [15:0] interdigit_gap_ms;
		logic [4:0]  pulse_limit;
	} cfg_t;

	// One input word.
	typedef struct packed {
		logic hook_level;
		logic session_start;
		logic decode_enable;
	} sample_t;

	// One result word.
	typedef struct packed {
		logic       digit_valid;
		logic [3:0] digit_value;
		logic [4:0] pulse_tally;
		logic       collecting;
		logic       edge_accepted;
	} result_t;

endpackage

// ===== hw/rtl/rpd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_in_if / rpd_out_if: sample and result channels
// Valid/ready channels carrying one hook sample word and one result word.
// ----------------------------------------------------------------------------
interface rpd_in_if;
	logic valid;
	logic ready;
	logic hook_level;
	logic session_start;
	logic decode_enable;

	modport source (output valid, hook_level, session_start, decode_enable, input ready);
	modport sink   (input valid, hook_level, session_start, decode_enable, output ready);
endinterface

interface rpd_out_if;
	logic       valid;
	logic       ready;
	logic       digit_valid;
	logic [3:0] digit_value;
	logic [4:0] pulse_tally;
	logic       collecting;
	logic       edge_accepted;

	modport source (output valid, digit_valid, digit_value, pulse_tally, collecting,
		edge_accepted, input ready);
	modport sink   (input valid, digit_valid, digit_value, pulse_tally, collecting,
		edge_accepted, output ready);
endinterface

// ===== hw/rtl/rpd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_core: pulse dial decoder state and step logic
// Holds the millisecond timers and train state, and computes the result of
// one sample in a single pass; state advances when step is high.
// ----------------------------------------------------------------------------
module rpd_core #(
	parameter int TIMER_BITS = rpd_pkg::TIMER_BITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  rpd_pkg::sample_t sample,
	input  rpd_pkg::cfg_t    cfg,
	output rpd_pkg::result_t res
);
	import rpd_pkg::*;

	// Compare width covers both the timers and the widest threshold.
	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	logic                  init_q;
	logic                  level_q;
	logic [TIMER_BITS-1:0] edge_t_q;
	logic [TIMER_BITS-1:0] make_t_q;
	logic [TIMER_BITS-1:0] brk_t_q;
	logic                  brk_valid_q;
	logic [TIMER_BITS-1:0] pulse_t_q;
	logic                  collect_q;
	logic [4:0]            count_q;

	logic                  init_d;
	logic                  level_d;
	logic [TIMER_BITS-1:0] edge_t_d;
	logic [TIMER_BITS-1:0] make_t_d;
	logic [TIMER_BITS-1:0] brk_t_d;
	logic                  brk_valid_d;
	logic [TIMER_BITS-1:0] pulse_t_d;
	logic                  collect_d;
	logic [4:0]            count_d;
	logic [TIMER_BITS-1:0] brk_len;
	logic                  edge_acc;
	logic                  dig_valid;
	logic [3:0]            dig_value;

	function automatic logic [TIMER_BITS-1:0] tick(input logic [TIMER_BITS-1:0] t);
		tick = (t == TIMER_MAX) ? TIMER_MAX : t + 1'b1;
	endfunction

	// Next state and result of one sample.
	always_comb begin
		init_d      = init_q;
		level_d     = level_q;
		edge_t_d    = tick(edge_t_q);
		make_t_d    = tick(make_t_q);
		brk_t_d     = tick(brk_t_q);
		brk_valid_d = brk_valid_q;
		pulse_t_d   = tick(pulse_t_q);
		collect_d   = collect_q;
		count_d     = count_q;
		brk_len     = '0;
		edge_acc    = 1'b0;
		dig_valid   = 1'b0;
		dig_value   = '0;

		if (sample.session_start) begin
			init_d      = 1'b0;
			level_d     = sample.hook_level;
			make_t_d    = '0;
			brk_t_d     = '0;
			brk_valid_d = 1'b0;
			pulse_t_d   = '0;
			edge_t_d    = TIMER_MAX;
			collect_d   = 1'b0;
			count_d     = '0;
		end else if (sample.decode_enable) begin
			if (!init_q) begin
				// First enabled sample records the level and clears the make and break timers.
				init_d      = 1'b1;
				level_d     = sample.hook_level;
				make_t_d    = '0;
				brk_t_d     = '0;
				brk_valid_d = 1'b0;
			end else if (sample.hook_level != level_q &&
				CW'(edge_t_d) >= CW'(cfg.edge_debounce_ms)) begin
				edge_acc = 1'b1;
				edge_t_d = '0;
				if (level_q) begin
					// Make to break: after a long enough make, opens or continues a train.
					if (CW'(make_t_d) >= CW'(cfg.make_min_ms)) begin
						if (!collect_q) begin
							collect_d = 1'b1;
							count_d   = '0;
						end
						brk_t_d     = '0;
						brk_valid_d = 1'b1;
					end
				end else begin
					// Break to make: a break of legal length in an open train below the pulse limit is a pulse.
					brk_len  = brk_valid_q ? brk_t_d : '0;
					make_t_d = '0;
					if (collect_q && count_q < cfg.pulse_limit &&
						CW'(brk_len) >= CW'(cfg.break_min_ms) &&
						CW'(brk_len) <= CW'(cfg.break_max_ms)) begin
						count_d   = count_q + 5'd1;
						pulse_t_d = '0;
					end
				end
				level_d = sample.hook_level;
			end

			// Inter-digit gap ends the train.
			if (sample.hook_level && collect_d && count_d != '0 &&
				CW'(pulse_t_d) >= CW'(cfg.interdigit_gap_ms)) begin
				if (count_d == TEN_PULSES) begin
					dig_valid = 1'b1;
				end else if (count_d < TEN_PULSES) begin
					dig_valid = 1'b1;
					dig_value = count_d[3:0];
				end
				collect_d = 1'b0;
				count_d   = '0;
			end
		end
	end

	assign res.digit_valid   = dig_valid;
	assign res.digit_value   = dig_value;
	assign res.pulse_tally   = count_d;
	assign res.collecting    = collect_d;
	assign res.edge_accepted = edge_acc;

	// Decoder state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= 1'b0;
			level_q     <= 1'b0;
			edge_t_q    <= TIMER_MAX;
			make_t_q    <= '0;
			brk_t_q     <= '0;
			brk_valid_q <= 1'b0;
			pulse_t_q   <= '0;
			collect_q   <= 1'b0;
			count_q     <= '0;
		end else if (step) begin
			init_q      <= init_d;
			level_q     <= level_d;
			edge_t_q    <= edge_t_d;
			make_t_q    <= make_t_d;
			brk_t_q     <= brk_t_d;
			brk_valid_q <= brk_valid_d;
			pulse_t_q   <= pulse_t_d;
			collect_q   <= collect_d;
			count_q     <= count_d;
		end
	end

	// A count is only ever held while a train is open.
	a_count_needs_train: assert property (@(posedge clk) disable iff (!arst_n)
		!collect_q |-> count_q == '0)
		else $error("pulse count nonzero outside a pulse train");

	// A session start leaves the decoder cleared.
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && sample.session_start |=> !collect_q && count_q == '0 && !init_q)
		else $error("session start did not clear the decoder");

	// An accepted edge restarts the debounce timer.
	a_edge_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.edge_accepted |=> edge_t_q == '0)
		else $error("accepted edge did not restart the debounce timer");

	// A digit is only emitted from an open train.
	a_digit_from_train: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.digit_valid |-> collect_q && !res.collecting)
		else $error("digit emitted without an open pulse train");

endmodule

// ===== hw/rtl/rotary_pulse_dial_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_pulse_dial_decoder_top: rotary loop-disconnect pulse dial decoder
// Takes one hook sample word per millisecond tick and returns one result
// word per sample with the decoded digit, pulse count and edge flags.
// ----------------------------------------------------------------------------
// Every sample word gives exactly one result word. The block accepts a new
// sample in every cycle while the result register is not stalled. A sample
// is held in the input register, and the decoder step logic reads it and
// writes its result into the result register. A stalled result holds the
// input register, and a further sample is taken once the result register
// moves. Registers are to be written through the configuration port only
// while no sample is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rotary_pulse_dial_decoder_top #(
	parameter int TIMER_BITS = rpd_pkg::TIMER_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rpd_in_if.sink                            dial_in,
	rpd_out_if.source                         dial_out,
	input  logic                              cfg_we,
	input  logic [rpd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rpd_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
	import rpd_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	sample_t sample_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t res;
	logic    adv;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_debounce_ms  <= RST_EDGE_DEBOUNCE;
			cfg_q.break_min_ms      <= RST_BREAK_MIN;
			cfg_q.break_max_ms      <= RST_BREAK_MAX;
			cfg_q.make_min_ms       <= RST_MAKE_MIN;
			cfg_q.interdigit_gap_ms <= RST_GAP;
			cfg_q.pulse_limit       <= RST_PULSE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EDGE_DEBOUNCE: cfg_q.edge_debounce_ms  <= cfg_wdata[9:0];
				REG_BREAK_MIN:     cfg_q.break_min_ms      <= cfg_wdata[9:0];
				REG_BREAK_MAX:     cfg_q.break_max_ms      <= cfg_wdata[9:0];
				REG_MAKE_MIN:      cfg_q.make_min_ms       <= cfg_wdata[9:0];
				REG_GAP:           cfg_q.interdigit_gap_ms <= cfg_wdata[15:0];
				REG_PULSE_LIMIT:   cfg_q.pulse_limit       <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	// The input word moves on when the result register is free or drains.
	assign adv           = valid_s1 && (!valid_s2 || dial_out.ready);
	assign dial_in.ready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (dial_in.valid && dial_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dial_in.valid && dial_in.ready) begin
			sample_s1.hook_level    <= dial_in.hook_level;
			sample_s1.session_start <= dial_in.session_start;
			sample_s1.decode_enable <= dial_in.decode_enable;
		end
	end

	rpd_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (dial_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= res;
		end
	end

	assign dial_out.valid         = valid_s2;
	assign dial_out.digit_valid   = result_s2.digit_valid;
	assign dial_out.digit_value   = result_s2.digit_value;
	assign dial_out.pulse_tally   = result_s2.pulse_tally;
	assign dial_out.collecting    = result_s2.collecting;
	assign dial_out.edge_accepted = result_s2.edge_accepted;

endmodule
